// ===== rtl/nrp_pkg.sv =====
package nrp_pkg;

    // Default sizes of the parser (handed to the top level parameters)
    localparam int BODY_MAX_DEF    = 99;
    localparam int FIELD_MAX_DEF   = 12;
    localparam int FIELD_CHARS_DEF = 19;
    localparam int FRAC_DIGITS_DEF = 5;

    // Field widths of a result word
    localparam int LAT_W     = 28;
    localparam int LON_W     = 29;
    localparam int MAG_W     = 28;   // unsigned magnitude out of the converter
    localparam int LAT_MAG_W = 27;

    // Integer part accumulator, saturating
    localparam int INT_W     = 17;
    localparam int INT_MUL_W = 21;   // holds 10 * INT_SAT + 9
    localparam logic [INT_W-1:0] INT_SAT = 17'd131071;

    // Divide by 100: (x * 5242) >> 19 lands on q or q - 1 for 17-bit x
    localparam int DIV100_MUL = 5242;
    localparam int DIV100_SH  = 19;
    localparam int DEG_W      = 11;  // whole degrees, up to 1310
    localparam int REM_W      = 8;   // remainder before correction, below 200

    // Minutes to millionths: floor((m * 10^(6-F) + 30) / 60), done as (n >> 2) / 15
    localparam int N_W        = 27;
    localparam int Y_W        = 25;
    localparam int DIV15_MUL  = 17895697;
    localparam int DIV15_SH   = 28;
    localparam int MICRO_W    = 21;
    localparam int DEGM_W     = 31;
    localparam int MICRO_DEG  = 1000000;
    localparam int ROUND_BIAS = 30;

    localparam logic [DEGM_W-1:0] LAT_LIMIT = 31'd90000000;
    localparam logic [DEGM_W-1:0] LON_LIMIT = 31'd180000000;

    // Pipeline depth of the coordinate converter
    localparam int CONV_LAT = 4;

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    // Sentence header "$GPRMC,"
    localparam int HDR_LEN = 7;

    // Field positions inside the body
    localparam int FLD_STATUS  = 1;
    localparam int FLD_LAT     = 2;
    localparam int FLD_LAT_HEM = 3;
    localparam int FLD_LON     = 4;
    localparam int FLD_LON_HEM = 5;

    // Sentence end event travelling alongside the converter
    typedef struct packed {
        logic valid;
        logic fix;
        logic south;
        logic west;
    } evt_t;

    // Converter output
    typedef struct packed {
        logic             valid;
        logic             is_lon;
        logic [MAG_W-1:0] mag;
    } conv_res_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h47;  // G
            3'd2:    c = 8'h50;  // P
            3'd3:    c = 8'h52;  // R
            3'd4:    c = 8'h4D;  // M
            3'd5:    c = 8'h43;  // C
            3'd6:    c = CH_COMMA;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic int pow10(input int n);
        int p;
        case (n)
            0:       p = 1;
            1:       p = 10;
            2:       p = 100;
            3:       p = 1000;
            4:       p = 10000;
            5:       p = 100000;
            6:       p = 1000000;
            default: p = 1;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/nrp_if.sv =====
// Received character stream
interface nrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, rx_byte, input ready);
    modport sink   (input valid, rx_byte, output ready);
endinterface

// Position result stream
interface nrp_result_if import nrp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    fix_valid;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;

    modport source (output valid, fix_valid, latitude, longitude, input ready);
    modport sink   (input valid, fix_valid, latitude, longitude, output ready);
endinterface

// ===== rtl/nrp_coord_conv.sv =====
module nrp_coord_conv import nrp_pkg::*;
#(
    parameter int  FRAC_DIGITS = FRAC_DIGITS_DEF,
    localparam int SCALE       = pow10(FRAC_DIGITS),
    localparam int FRAC_W      = $clog2(SCALE),
    localparam int CNT_W       = $clog2(FRAC_DIGITS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              launch_valid,
    input  logic              launch_lon,
    input  logic [INT_W-1:0]  int_val,
    input  logic [FRAC_W-1:0] frac_val,
    input  logic [CNT_W-1:0]  frac_cnt,
    output conv_res_t         res
);

    localparam int PW_W = $clog2(SCALE + 1);
    localparam int M_W  = $clog2(100 * SCALE);
    localparam int TAIL = pow10(6 - FRAC_DIGITS);
    localparam int QP_W = INT_W + 13;
    localparam int FP_W = FRAC_W + PW_W;
    localparam int DP_W = 2 * Y_W;

    // Stage registers
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic              s1_lon_reg, s2_lon_reg, s3_lon_reg, s4_lon_reg;
    logic [DEG_W-1:0]  s1_q_reg, s2_deg_reg;
    logic [REM_W-1:0]  s1_r_reg;
    logic [FRAC_W-1:0] s1_fterm_reg;
    logic [M_W-1:0]    s2_m_reg;
    logic [DEGM_W-1:0] s3_degm_reg, s4_degm_reg;
    logic [Y_W-1:0]    s3_y_reg, s4_y_reg;
    logic [MICRO_W-1:0] s4_q_reg;

    // Stage 1: split off whole degrees, align the fraction
    logic [QP_W-1:0]   q_prod;
    logic [DEG_W-1:0]  q_est;
    logic [INT_W-1:0]  hund;
    logic [INT_W-1:0]  r_full;
    logic [PW_W-1:0]   pw;
    logic [FP_W-1:0]   f_prod;

    assign q_prod = QP_W'(int_val) * QP_W'(DIV100_MUL);
    assign q_est  = q_prod[DIV100_SH +: DEG_W];
    assign hund   = INT_W'(q_est) * INT_W'(100);
    assign r_full = int_val - hund;
    assign pw     = PW_W'(pow10(FRAC_DIGITS - int'(frac_cnt)));
    assign f_prod = FP_W'(frac_val) * FP_W'(pw);

    // Stage 2: correct the quotient, build minutes scaled by 10^F
    logic [DEG_W-1:0]  deg;
    logic [REM_W-1:0]  rem;
    logic [M_W-1:0]    m_val;

    always_comb
    begin
        if (s1_r_reg >= REM_W'(100))
        begin
            deg = s1_q_reg + 1'b1;
            rem = s1_r_reg - REM_W'(100);
        end
        else
        begin
            deg = s1_q_reg;
            rem = s1_r_reg;
        end
    end

    assign m_val = M_W'(rem) * M_W'(SCALE) + M_W'(s1_fterm_reg);

    // Stage 3: rounding bias, pre-divide by 4, degrees to millionths
    logic [N_W-1:0]    n_val;
    logic [DEGM_W-1:0] degm;

    assign n_val = N_W'(s2_m_reg) * N_W'(TAIL) + N_W'(ROUND_BIAS);
    assign degm  = DEGM_W'(s2_deg_reg) * DEGM_W'(MICRO_DEG);

    // Stage 4: divide by 15 by reciprocal
    logic [DP_W-1:0]   d_prod;

    assign d_prod = DP_W'(s3_y_reg) * DP_W'(DIV15_MUL);

    // Output: one-step quotient correction, sum and saturate
    logic [Y_W-1:0]     fifteen;
    logic [Y_W-1:0]     ra;
    logic [MICRO_W-1:0] micro;
    logic [DEGM_W-1:0]  total;
    logic [DEGM_W-1:0]  limit;

    assign fifteen = Y_W'(s4_q_reg) * Y_W'(15);
    assign ra      = s4_y_reg - fifteen;
    assign micro   = s4_q_reg + MICRO_W'(ra >= Y_W'(15));
    assign total   = s4_degm_reg + DEGM_W'(micro);
    assign limit   = s4_lon_reg ? LON_LIMIT : LAT_LIMIT;

    assign res.valid  = s4_valid_reg;
    assign res.is_lon = s4_lon_reg;
    assign res.mag    = (total > limit) ? limit[MAG_W-1:0] : total[MAG_W-1:0];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= launch_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Data path
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_lon_reg   <= launch_lon;
            s1_q_reg     <= q_est;
            s1_r_reg     <= r_full[REM_W-1:0];
            s1_fterm_reg <= f_prod[FRAC_W-1:0];

            s2_lon_reg   <= s1_lon_reg;
            s2_deg_reg   <= deg;
            s2_m_reg     <= m_val;

            s3_lon_reg   <= s2_lon_reg;
            s3_degm_reg  <= degm;
            s3_y_reg     <= n_val[N_W-1:2];

            s4_lon_reg   <= s3_lon_reg;
            s4_degm_reg  <= s3_degm_reg;
            s4_y_reg     <= s3_y_reg;
            s4_q_reg     <= d_prod[DIV15_SH +: MICRO_W];
        end
    end

endmodule

// ===== rtl/nmea_rmc_position_parser.sv =====
// NMEA RMC position parser. Takes one received character per clock on rx and hunts for
// "$GPRMC,"; the body is split at commas by position, status must be 'A' and at least six
// fields must arrive for a fix. Latitude and longitude are converted to signed millionths
// of a degree (south and west negative) by a four-stage converter; every '*' ending a body
// gives one result word on result carrying the fix flag and the last position from a
// sentence with a fix. A character is accepted every clock unless rx is held off; the
// result word passes four converter stages, then the output register. rx is held off
// only while a second result has reached the output and the first one has not been taken.
module nmea_rmc_position_parser import nrp_pkg::*;
#(
    parameter int BODY_MAX    = BODY_MAX_DEF,
    parameter int FIELD_MAX   = FIELD_MAX_DEF,
    parameter int FIELD_CHARS = FIELD_CHARS_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    nrp_byte_if.sink            rx,
    nrp_result_if.source        result
);

    localparam int BC_W   = $clog2(BODY_MAX + 1);
    localparam int FI_W   = $clog2(FIELD_MAX + 1);
    localparam int FC_W   = $clog2(FIELD_CHARS + 1);
    localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam int FRAC_W = $clog2(pow10(FRAC_DIGITS));

    // Parser state
    logic [2:0]         header_pos_reg, header_pos_next;
    logic               in_body_reg, in_body_next;
    logic [BC_W-1:0]    body_count_reg, body_count_next;
    logic [FI_W-1:0]    field_index_reg, field_index_next;
    logic [FC_W-1:0]    field_chars_reg, field_chars_next;
    logic               status_ok_reg, status_ok_next;
    logic [INT_W-1:0]   int_accum_reg, int_accum_next;
    logic [FRAC_W-1:0]  frac_accum_reg, frac_accum_next;
    logic [CNT_W-1:0]   frac_cnt_reg, frac_cnt_next;
    logic               point_seen_reg, point_seen_next;
    logic               num_done_reg, num_done_next;
    logic               hem_south_reg, hem_south_next;
    logic               hem_west_reg, hem_west_next;

    // Position state
    logic [LAT_MAG_W-1:0]    lat_pending_reg;
    logic [MAG_W-1:0]        lon_pending_reg;
    logic signed [LAT_W-1:0] last_lat_reg;
    logic signed [LON_W-1:0] last_lon_reg;

    // Sentence end events, aligned with the converter
    evt_t evt_reg [CONV_LAT];
    evt_t evt_new;
    evt_t evt_out;

    // Output register
    logic                    out_valid_reg;
    logic                    out_fix_reg;
    logic signed [LAT_W-1:0] out_lat_reg;
    logic signed [LON_W-1:0] out_lon_reg;

    logic      adv;
    logic      accept;
    logic      launch_valid;
    logic      launch_lon;
    conv_res_t conv_res;

    // Everything moves unless a second result would land on an untaken one
    assign evt_out = evt_reg[CONV_LAT-1];
    assign adv     = !(evt_out.valid && out_valid_reg && !result.ready);
    assign accept  = rx.valid && adv;
    assign rx.ready = adv;

    // Per-character parse
    always_comb
    begin
        logic [7:0] b;
        logic       is_digit;
        logic [3:0] dig;
        logic [7:0] dig_full;
        logic [INT_MUL_W-1:0] int_ext;

        b        = rx.rx_byte;
        is_digit = b inside {[CH_ZERO:CH_NINE]};
        dig_full = b - CH_ZERO;
        dig      = dig_full[3:0];
        int_ext  = INT_MUL_W'(int_accum_reg) * INT_MUL_W'(10) + INT_MUL_W'(dig);

        header_pos_next  = header_pos_reg;
        in_body_next     = in_body_reg;
        body_count_next  = body_count_reg;
        field_index_next = field_index_reg;
        field_chars_next = field_chars_reg;
        status_ok_next   = status_ok_reg;
        int_accum_next   = int_accum_reg;
        frac_accum_next  = frac_accum_reg;
        frac_cnt_next    = frac_cnt_reg;
        point_seen_next  = point_seen_reg;
        num_done_next    = num_done_reg;
        hem_south_next   = hem_south_reg;
        hem_west_next    = hem_west_reg;
        launch_valid     = 1'b0;
        launch_lon       = 1'b0;
        evt_new          = '0;

        if (accept)
        begin
            if (!in_body_reg)
            begin
                // Header hunt; a stray '$' counts as a fresh start
                if (b == hdr_char(header_pos_reg))
                begin
                    if (header_pos_reg == 3'(HDR_LEN - 1))
                    begin
                        in_body_next     = 1'b1;
                        header_pos_next  = '0;
                        body_count_next  = '0;
                        field_index_next = '0;
                        field_chars_next = '0;
                        status_ok_next   = 1'b0;
                        hem_south_next   = 1'b0;
                        hem_west_next    = 1'b0;
                        int_accum_next   = '0;
                        frac_accum_next  = '0;
                        frac_cnt_next    = '0;
                        point_seen_next  = 1'b0;
                        num_done_next    = 1'b0;
                    end
                    else
                    begin
                        header_pos_next = header_pos_reg + 1'b1;
                    end
                end
                else
                begin
                    header_pos_next = (b == CH_DOLLAR) ? 3'd1 : 3'd0;
                end
            end
            else if (b == CH_STAR)
            begin
                evt_new.valid   = 1'b1;
                evt_new.fix     = status_ok_reg && (field_index_reg >= FI_W'(FLD_LON_HEM));
                evt_new.south   = hem_south_reg;
                evt_new.west    = hem_west_reg;
                in_body_next    = 1'b0;
                header_pos_next = '0;
            end
            else if (body_count_reg < BC_W'(BODY_MAX))
            begin
                body_count_next = body_count_reg + 1'b1;
                if (b == CH_COMMA)
                begin
                    // Coordinate field closed: hand the number to the converter
                    launch_lon   = (field_index_reg == FI_W'(FLD_LON));
                    launch_valid = (field_index_reg == FI_W'(FLD_LAT)) || launch_lon;
                    if (field_index_reg < FI_W'(FIELD_MAX))
                    begin
                        field_index_next = field_index_reg + 1'b1;
                    end
                    field_chars_next = '0;
                    int_accum_next   = '0;
                    frac_accum_next  = '0;
                    frac_cnt_next    = '0;
                    point_seen_next  = 1'b0;
                    num_done_next    = 1'b0;
                end
                else if (field_chars_reg < FC_W'(FIELD_CHARS))
                begin
                    field_chars_next = field_chars_reg + 1'b1;
                    case (field_index_reg)
                        FI_W'(FLD_STATUS):
                        begin
                            status_ok_next = (field_chars_reg == '0) && (b == CH_A);
                        end
                        FI_W'(FLD_LAT), FI_W'(FLD_LON):
                        begin
                            if (!num_done_reg)
                            begin
                                if (is_digit)
                                begin
                                    if (!point_seen_reg)
                                    begin
                                        int_accum_next = (int_ext > INT_MUL_W'(INT_SAT)) ?
                                            INT_SAT : int_ext[INT_W-1:0];
                                    end
                                    else if (frac_cnt_reg < CNT_W'(FRAC_DIGITS))
                                    begin
                                        frac_accum_next = frac_accum_reg * FRAC_W'(10)
                                                        + FRAC_W'(dig);
                                        frac_cnt_next   = frac_cnt_reg + 1'b1;
                                    end
                                end
                                else if (b == CH_POINT && !point_seen_reg)
                                begin
                                    point_seen_next = 1'b1;
                                end
                                else
                                begin
                                    num_done_next = 1'b1;
                                end
                            end
                        end
                        FI_W'(FLD_LAT_HEM):
                        begin
                            if (field_chars_reg == '0 && b == CH_S)
                            begin
                                hem_south_next = 1'b1;
                            end
                        end
                        FI_W'(FLD_LON_HEM):
                        begin
                            if (field_chars_reg == '0 && b == CH_W)
                            begin
                                hem_west_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // Coordinate converter
    nrp_coord_conv #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .launch_valid (launch_valid),
        .launch_lon   (launch_lon),
        .int_val      (int_accum_reg),
        .frac_val     (frac_accum_reg),
        .frac_cnt     (frac_cnt_reg),
        .res          (conv_res)
    );

    // Signed position of the sentence now finishing
    logic [LAT_W-1:0]        lat_mag;
    logic [LON_W-1:0]        lon_mag;
    logic signed [LAT_W-1:0] lat_new;
    logic signed [LON_W-1:0] lon_new;

    assign lat_mag = {1'b0, lat_pending_reg};
    assign lon_mag = {1'b0, lon_pending_reg};
    assign lat_new = evt_out.south ? -$signed(lat_mag) : $signed(lat_mag);
    assign lon_new = evt_out.west  ? -$signed(lon_mag) : $signed(lon_mag);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg  <= '0;
            in_body_reg     <= 1'b0;
            body_count_reg  <= '0;
            field_index_reg <= '0;
            field_chars_reg <= '0;
            status_ok_reg   <= 1'b0;
            int_accum_reg   <= '0;
            frac_accum_reg  <= '0;
            frac_cnt_reg    <= '0;
            point_seen_reg  <= 1'b0;
            num_done_reg    <= 1'b0;
            hem_south_reg   <= 1'b0;
            hem_west_reg    <= 1'b0;
            last_lat_reg    <= '0;
            last_lon_reg    <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < CONV_LAT; i++)
            begin
                evt_reg[i] <= '0;
            end
        end
        else
        begin
            header_pos_reg  <= header_pos_next;
            in_body_reg     <= in_body_next;
            body_count_reg  <= body_count_next;
            field_index_reg <= field_index_next;
            field_chars_reg <= field_chars_next;
            status_ok_reg   <= status_ok_next;
            int_accum_reg   <= int_accum_next;
            frac_accum_reg  <= frac_accum_next;
            frac_cnt_reg    <= frac_cnt_next;
            point_seen_reg  <= point_seen_next;
            num_done_reg    <= num_done_next;
            hem_south_reg   <= hem_south_next;
            hem_west_reg    <= hem_west_next;

            if (adv)
            begin
                evt_reg[0] <= evt_new;
                for (int i = 1; i < CONV_LAT; i++)
                begin
                    evt_reg[i] <= evt_reg[i-1];
                end
                if (evt_out.valid && evt_out.fix)
                begin
                    last_lat_reg <= lat_new;
                    last_lon_reg <= lon_new;
                end
            end

            // Output word handshake
            if (adv && evt_out.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pending magnitudes and output payload
    always_ff @(posedge clk)
    begin
        if (adv && conv_res.valid)
        begin
            if (conv_res.is_lon)
            begin
                lon_pending_reg <= conv_res.mag;
            end
            else
            begin
                lat_pending_reg <= conv_res.mag[LAT_MAG_W-1:0];
            end
        end
        if (adv && evt_out.valid)
        begin
            out_fix_reg <= evt_out.fix;
            out_lat_reg <= evt_out.fix ? lat_new : last_lat_reg;
            out_lon_reg <= evt_out.fix ? lon_new : last_lon_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.fix_valid = out_fix_reg;
    assign result.latitude  = out_lat_reg;
    assign result.longitude = out_lon_reg;

endmodule

// ===== tb/rmc_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the RMC parser, tracks its sentence state from the
// character words it takes and checks every position report it hands out.
module rmc_checker
    import nrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    nrp_byte_if     rx,
    nrp_result_if   result,
    output int      errors,
    output int      pending,
    output int      reports_made,
    output int      fixes_made
);

    // Parser sizes
    localparam int  BODY_LIMIT  = 99;
    localparam int  FIELD_LIMIT = 12;
    localparam int  CHAR_LIMIT  = 19;
    localparam int  FRAC_LIMIT  = 5;
    localparam int  INT_CEIL    = 131071;
    localparam longint LAT_CAP  = 90000000;
    localparam longint LON_CAP  = 180000000;
    localparam longint MICRO    = 1000000;

    localparam string RMC_HDR = "$GPRMC,";
    localparam int    HDR_LAST = 6;

    // Characters the parser reacts to
    localparam logic [7:0] CHR_DOLLAR = "$";
    localparam logic [7:0] CHR_STAR   = "*";
    localparam logic [7:0] CHR_COMMA  = ",";
    localparam logic [7:0] CHR_POINT  = ".";
    localparam logic [7:0] CHR_ZERO   = "0";
    localparam logic [7:0] CHR_NINE   = "9";
    localparam logic [7:0] CHR_FIX    = "A";
    localparam logic [7:0] CHR_SOUTH  = "S";
    localparam logic [7:0] CHR_WEST   = "W";

    // Field positions in the body
    localparam int POS_STATUS = 1;
    localparam int POS_LAT    = 2;
    localparam int POS_NS     = 3;
    localparam int POS_LON    = 4;
    localparam int POS_EW     = 5;

    typedef struct {
        logic                    fix;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } rmc_report_t;

    rmc_report_t reports_due[$];

    // Sentence tracking state
    logic [2:0]              hdr_pos;
    logic                    in_body;
    logic [6:0]              body_cnt;
    logic [3:0]              fld;
    logic [4:0]              fld_chars;
    logic                    stat_ok;
    logic [16:0]             int_acc;
    logic [16:0]             frac_acc;
    logic [2:0]              frac_cnt;
    logic                    pt_seen;
    logic                    num_done;
    logic [LAT_W-2:0]        lat_mag;
    logic [LON_W-2:0]        lon_mag;
    logic                    south;
    logic                    west;
    logic signed [LAT_W-1:0] fix_lat;
    logic signed [LON_W-1:0] fix_lon;

    int err_cnt;
    int made_cnt;
    int fix_cnt;

    // ddmm.mmmmm in the accumulators to millionths of a degree, rounded, capped
    function automatic longint coord_micro(input longint cap);
        longint scale;
        longint whole_deg;
        longint mins;
        longint micro_part;
        longint total;
        int     k;
        k          = (frac_cnt > FRAC_LIMIT) ? FRAC_LIMIT : int'(frac_cnt);
        scale      = 10 ** FRAC_LIMIT;
        whole_deg  = longint'(int_acc) / 100;
        mins       = (longint'(int_acc) % 100) * scale
                   + longint'(frac_acc) * (10 ** (FRAC_LIMIT - k));
        micro_part = (mins * MICRO + 30 * scale) / (60 * scale);
        total      = whole_deg * MICRO + micro_part;
        return (total > cap) ? cap : total;
    endfunction

    // One character word taken by the parser
    task automatic parse_char(input logic [7:0] c);
        int          pos;
        int          grown;
        rmc_report_t rep;
        if (!in_body) begin
            // header hunt
            if (c == RMC_HDR[hdr_pos]) begin
                if (hdr_pos == HDR_LAST) begin
                    in_body   = 1'b1;
                    hdr_pos   = '0;
                    body_cnt  = '0;
                    fld       = '0;
                    fld_chars = '0;
                    stat_ok   = 1'b0;
                    lat_mag   = '0;
                    lon_mag   = '0;
                    south     = 1'b0;
                    west      = 1'b0;
                    int_acc   = '0;
                    frac_acc  = '0;
                    frac_cnt  = '0;
                    pt_seen   = 1'b0;
                    num_done  = 1'b0;
                end
                else begin
                    hdr_pos = hdr_pos + 3'd1;
                end
            end
            else begin
                hdr_pos = (c == CHR_DOLLAR) ? 3'd1 : 3'd0;
            end
        end
        else if (c == CHR_STAR) begin
            // sentence end: one report
            rep.fix = stat_ok && (fld >= POS_EW);
            if (rep.fix) begin
                fix_lat = south ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
                fix_lon = west  ? -$signed({1'b0, lon_mag}) : $signed({1'b0, lon_mag});
                fix_cnt++;
            end
            rep.lat = fix_lat;
            rep.lon = fix_lon;
            reports_due.push_back(rep);
            made_cnt++;
            in_body = 1'b0;
            hdr_pos = '0;
        end
        else if (body_cnt < BODY_LIMIT) begin
            body_cnt = body_cnt + 7'd1;
            if (c == CHR_COMMA) begin
                if (fld == POS_LAT)
                    lat_mag = (LAT_W-1)'(coord_micro(LAT_CAP));
                else if (fld == POS_LON)
                    lon_mag = (LON_W-1)'(coord_micro(LON_CAP));
                if (fld < FIELD_LIMIT)
                    fld = fld + 4'd1;
                fld_chars = '0;
                int_acc   = '0;
                frac_acc  = '0;
                frac_cnt  = '0;
                pt_seen   = 1'b0;
                num_done  = 1'b0;
            end
            else if (fld_chars < CHAR_LIMIT) begin
                pos       = int'(fld_chars);
                fld_chars = fld_chars + 5'd1;
                case (int'(fld))
                    POS_STATUS: stat_ok = (pos == 0) && (c == CHR_FIX);
                    POS_LAT, POS_LON: begin
                        // number scan; any stray char freezes what was read
                        if (!num_done) begin
                            if (c >= CHR_ZERO && c <= CHR_NINE) begin
                                if (!pt_seen) begin
                                    grown   = int'(int_acc) * 10 + int'(c - CHR_ZERO);
                                    int_acc = (grown > INT_CEIL) ? 17'(INT_CEIL) : 17'(grown);
                                end
                                else if (frac_cnt < FRAC_LIMIT) begin
                                    frac_acc = frac_acc * 17'd10 + 17'(c - CHR_ZERO);
                                    frac_cnt = frac_cnt + 3'd1;
                                end
                            end
                            else if (c == CHR_POINT && !pt_seen) begin
                                pt_seen = 1'b1;
                            end
                            else begin
                                num_done = 1'b1;
                            end
                        end
                    end
                    POS_NS: if (pos == 0 && c == CHR_SOUTH) south = 1'b1;
                    POS_EW: if (pos == 0 && c == CHR_WEST) west = 1'b1;
                    default: ;
                endcase
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hdr_pos   = '0;
            in_body   = 1'b0;
            body_cnt  = '0;
            fld       = '0;
            fld_chars = '0;
            stat_ok   = 1'b0;
            int_acc   = '0;
            frac_acc  = '0;
            frac_cnt  = '0;
            pt_seen   = 1'b0;
            num_done  = 1'b0;
            lat_mag   = '0;
            lon_mag   = '0;
            south     = 1'b0;
            west      = 1'b0;
            fix_lat   = '0;
            fix_lon   = '0;
            err_cnt   = 0;
            made_cnt  = 0;
            fix_cnt   = 0;
            reports_due.delete();
        end
        else begin
            // report word leaving the parser
            if (result.valid && result.ready) begin
                if (reports_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t: report with none due: fix=%0b lat=%0d lon=%0d", $time,
                             result.fix_valid, result.latitude, result.longitude);
                end
                else begin
                    rmc_report_t want;
                    want = reports_due.pop_front();
                    if (result.fix_valid !== want.fix) begin
                        err_cnt++;
                        $display("%0t: fix_valid expected %0b got %0b", $time,
                                 want.fix, result.fix_valid);
                    end
                    if (result.latitude !== want.lat) begin
                        err_cnt++;
                        $display("%0t: latitude expected %0d got %0d", $time,
                                 want.lat, result.latitude);
                    end
                    if (result.longitude !== want.lon) begin
                        err_cnt++;
                        $display("%0t: longitude expected %0d got %0d", $time,
                                 want.lon, result.longitude);
                    end
                end
            end
            // character word entering the parser
            if (rx.valid && rx.ready)
                parse_char(rx.rx_byte);
        end
        errors       <= err_cnt;
        pending      <= reports_due.size();
        reports_made <= made_cnt;
        fixes_made   <= fix_cnt;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int HOLD_CYCLES     = 400;
    localparam int CHAR_TARGET     = 1200;
    localparam int NOGAP_SENTENCES = 4;
    localparam int DRAIN_WAIT      = 20;

    logic clk = 1'b0;
    logic rst_n;

    nrp_byte_if   byte_if ();
    nrp_result_if res_if ();

    int errors;
    int pending;
    int reports_made;
    int fixes_made;

    int  sent_chars;
    int  rx_stalls = 0;
    int  hold_asks;
    int  holds_done;
    int  hold_left;
    bit  idle_on;
    logic [7:0] line_q[$];

    nmea_rmc_position_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (byte_if),
        .result (res_if)
    );

    rmc_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (byte_if),
        .result       (res_if),
        .errors       (errors),
        .pending      (pending),
        .reports_made (reports_made),
        .fixes_made   (fixes_made)
    );

    always #10 clk = ~clk;

    // Run limit
    initial
    begin
        #5ms;
        $display("tb failed");
        $finish;
    end

    // Cycles the parser holds off its input
    always @(posedge clk)
    begin
        if (rst_n && byte_if.valid && !byte_if.ready)
            rx_stalls <= rx_stalls + 1;
    end

    // Result side: random stalls, plus long hold-offs on request
    initial
    begin
        holds_done = 0;
        hold_left  = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else begin
                res_if.ready <= !(idle_on && $urandom_range(99) < 33);
            end
        end
    end

    // Offer one character word, with random gaps ahead of it
    task automatic send_char(input logic [7:0] c);
        while (idle_on && $urandom_range(99) < 33) begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.rx_byte <= c;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        repeat (n)
            line_q.push_back(8'("0" + $urandom_range(9)));
    endtask

    // Printable filler that keeps the field structure
    task automatic add_filler(input int n);
        logic [7:0] c;
        repeat (n)
        begin
            do
                c = 8'($urandom_range(32, 126));
            while (c == "," || c == "*");
            line_q.push_back(c);
        end
    endtask

    // Coordinate text: whole part, optional point and fraction, rare stray chars
    task automatic add_coord(input int whole_len);
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return;
        if (r == 1) begin
            add_digits($urandom_range(20, 26));
            return;
        end
        add_digits(($urandom_range(3) == 0) ? $urandom_range(0, 8) : whole_len);
        if ($urandom_range(7) != 0) begin
            line_q.push_back(".");
            add_digits($urandom_range(0, 7));
        end
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: line_q.push_back(".");
                1: line_q.push_back("-");
                2: line_q.push_back("+");
                default: line_q.push_back(8'($urandom_range(255)));
            endcase
            add_digits($urandom_range(0, 3));
        end
    endtask

    // One random sentence, mostly well formed
    task automatic make_sentence();
        int    nfld;
        int    r;
        string hdr;
        hdr = "$GPRMC,";
        line_q.delete();
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4))
                line_q.push_back(8'($urandom_range(255)));
        if ($urandom_range(7) == 0) begin
            add_text(hdr.substr(0, $urandom_range(0, 5)));
            line_q.push_back(($urandom_range(1) == 0) ? 8'("$") : 8'($urandom_range(255)));
        end
        add_text(hdr);
        r = $urandom_range(9);
        nfld = (r == 0) ? $urandom_range(0, 16) : (r == 1) ? $urandom_range(0, 5)
                                                            : $urandom_range(6, 9);
        for (int f = 0; f < nfld; f++)
        begin
            if (f > 0)
                line_q.push_back(",");
            r = $urandom_range(15);
            case (f)
                0: add_digits($urandom_range(0, 9));
                1: begin
                    if (r < 11)       add_text("A");
                    else if (r < 13)  add_text("V");
                    else if (r == 13) add_text("AA");
                    else if (r == 14) line_q.push_back(8'($urandom_range(255)));
                end
                2: add_coord(4);
                3: begin
                    if (r < 7)        add_text("N");
                    else if (r < 14)  add_text("S");
                    else if (r == 14) add_text("XS");
                end
                4: add_coord(5);
                5: begin
                    if (r < 7)        add_text("E");
                    else if (r < 14)  add_text("W");
                    else if (r == 14) add_text("WW");
                end
                default: add_filler(($urandom_range(24) == 0) ? 110 : $urandom_range(0, 8));
            endcase
        end
        line_q.push_back("*");
        if ($urandom_range(3) != 0)
            add_text("4F\r\n");
    endtask

    // Stimulus
    initial
    begin
        rst_n           <= 1'b0;
        byte_if.valid   <= 1'b0;
        byte_if.rx_byte <= 8'h00;
        sent_chars = 0;
        hold_asks  = 0;
        idle_on    = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sentences
        send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
        send_text("$GPRMC,,A,3345.12345,S,15112.5,W*");
        send_text("$GPRMC,,V,1111.1,N,02222.2,E*");
        send_text("$GPRMC,,A,1234.5,N,00100.0*");
        send_text("$GPRMC,,A,9959.99999,N,99999999.9,E*");
        send_text("$GPRMC,,A,0000.00003,S,00000.00000,W*");
        send_text("$GPRMC,,A,1234.5678999,N,12.3.4,E*");
        send_text("$GPRMC,,A,-1234.5,N,0123x4.5,W*");
        send_text("$GPRMC,,A,,N,,E*");
        send_text("$GP$GPRMC,,A,0100.0,SX,00100.0,XW*");
        send_text("$$GPRMC,,AA,0200.0,N,00200.0,E*");
        send_text("$GPRMX,$GPRMC,,A,0300.0,N,00300.0,E,$,,,,,,,,,,,,,*");
        send_text("$GPRMC,,A,00000000000000000004512.5,N,00000.0,E*");
        send_text("$GPRMC,,A,8959.99999,S,17959.99999,W*");
        send_text("$GPRMC,*");
        // long body: the tail past the limit is dropped, the star still ends it
        send_text("$GPRMC,,A,0400.0,N,00400.0,E,");
        repeat (100) send_char("Z");
        send_char("*");
        // raw noise outside any sentence, including a stray star
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'hAA);
        send_char(8'h55);
        send_char(8'hA4);
        send_char("*");
        send_text("$GPRMC,,A,4500.0,S,09000.0,W,,*");

        // Pause until every report has come out
        byte_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);

        // Long hold-off on the result side while short sentences keep coming
        hold_asks++;
        repeat (12) send_text("$GPRMC,,A,0100.5,N,00200.25,E*");

        // Random sentences, the first few with no gaps on either side
        for (int n = 0; sent_chars < CHAR_TARGET || n < NOGAP_SENTENCES; n++)
        begin
            idle_on = (n >= NOGAP_SENTENCES);
            make_sentence();
            foreach (line_q[i])
                send_char(line_q[i]);
        end
        idle_on = 1'b1;
        byte_if.valid <= 1'b0;

        // Drain
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d characters; %0d position reports checked, %0d of them with a fix.",
                 sent_chars, reports_made, fixes_made);
        $display("Input held off for %0d cycles while the result side stalled.", rx_stalls);
        if (errors == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
